// File: rtl/ssort_pkg.sv
package ssort_pkg;

    localparam int WORD_W = 32;

    // One element of the set, two's complement.
    typedef logic signed [WORD_W-1:0] t_word;

endpackage

// File: rtl/ssort_ram.sv
// Element store: one write port, one read port, registered read data.
module ssort_ram #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  ssort_pkg::t_word           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output ssort_pkg::t_word           o_rdata
);
    import ssort_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/selection_sorter_core.sv
// Selection sorter. Signed 32-bit words stream in on the slave side, one per
// accepted word, into an element store of DEPTH entries; the word with tlast
// set closes the set. Words arriving while the store is full are dropped and
// every output word of that set then carries tuser = 1. Once the set is
// closed, s_axis_tready goes low while the block sorts the store in place,
// ascending, by selection (earliest among equal values wins), then streams the
// sorted words out on the master side with tlast on the final one; the slave
// side reopens as soon as the last word sits in the output register. For a
// set of n held words, the sort walks the single read port of the store,
// scanning positions pos..n-1 for each pos from 0 to n-2, then swapping with
// two writes; emission reads each word from the store, then puts it in the
// output register, and holds it there while the sink stalls.
module selection_sorter_core #(
    parameter int DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,   // [31:0] sample_value
    input  logic                   s_axis_tlast,   // is_last
    // master side
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [31:0]            m_axis_tdata,   // [31:0] sorted_value
    output logic                   m_axis_tlast,   // run_end
    output logic                   m_axis_tuser    // [0] dropped_flag
);
    import ssort_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_SWAP_A = 3'd2;
    localparam logic [2:0] ST_SWAP_B = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    // control
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;   // words held
    logic          r_ovf,   n_ovf;     // a word was dropped
    logic [AW-1:0] r_pos,   n_pos;     // position being filled
    logic [CW-1:0] r_iss,   n_iss;     // next scan read address
    logic          r_dvld,  n_dvld;    // scan read data valid this cycle
    logic [AW-1:0] r_eidx,  n_eidx;    // next emit read address
    logic          r_pend,  n_pend;    // emit read data arrives this cycle
    logic          r_oval,  n_oval;
    // payload
    logic [AW-1:0] r_didx,  n_didx;    // address of returning scan data
    logic          r_plast, n_plast;
    t_word         r_best,  n_best;
    logic [AW-1:0] r_bidx,  n_bidx;
    t_word         r_posval, n_posval;
    t_word         r_odata, n_odata;
    logic          r_olast, n_olast;
    logic          r_ouser, n_ouser;

    // store port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_word         mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_word         mem_rdata;

    logic          in_acc;
    logic          out_acc;
    logic          full;
    logic [CW-1:0] last_idx;

    ssort_ram #(.DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign s_axis_tready = (r_state == ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = r_oval && m_axis_tready;
    assign full          = (r_count == CW'(DEPTH));
    assign last_idx      = r_count - CW'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_pos    = r_pos;
        n_iss    = r_iss;
        n_dvld   = 1'b0;
        n_eidx   = r_eidx;
        n_pend   = 1'b0;
        n_oval   = r_oval;
        n_didx   = r_didx;
        n_plast  = r_plast;
        n_best   = r_best;
        n_bidx   = r_bidx;
        n_posval = r_posval;
        n_odata  = r_odata;
        n_olast  = r_olast;
        n_ouser  = r_ouser;
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = s_axis_tdata;
        mem_raddr = r_iss[AW-1:0];

        // output register: drains on accept, refilled from the store
        if (out_acc) begin
            n_oval = 1'b0;
        end
        if (r_pend) begin
            n_oval  = 1'b1;
            n_odata = mem_rdata;
            n_olast = r_plast;
            n_ouser = r_ovf;
        end

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (!full) begin
                        mem_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_pos  = '0;
                        n_iss  = '0;
                        n_eidx = '0;
                        // a set of one word needs no sort
                        if (n_count == CW'(1)) begin
                            n_state = ST_EMIT;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // issue reads pos..n-1, compare as data returns
                if (r_iss < r_count) begin
                    n_iss  = r_iss + CW'(1);
                    n_dvld = 1'b1;
                    n_didx = r_iss[AW-1:0];
                end
                if (r_dvld) begin
                    if (r_didx == r_pos) begin
                        n_best   = mem_rdata;
                        n_bidx   = r_pos;
                        n_posval = mem_rdata;
                    end else if (mem_rdata < r_best) begin
                        n_best = mem_rdata;
                        n_bidx = r_didx;
                    end
                    if (CW'(r_didx) == last_idx) begin
                        n_state = ST_SWAP_A;
                    end
                end
            end
            ST_SWAP_A: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_best;
                n_state   = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                mem_we    = 1'b1;
                mem_waddr = r_bidx;
                mem_wdata = r_posval;
                n_pos     = r_pos + AW'(1);
                n_iss     = CW'(r_pos) + CW'(1);
                if (CW'(r_pos) + CW'(2) == r_count) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_EMIT: begin
                mem_raddr = r_eidx;
                if (r_pend) begin
                    if (r_plast) begin
                        n_state = ST_LOAD;
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end
                end else if (!r_oval || m_axis_tready) begin
                    n_pend  = 1'b1;
                    n_plast = (CW'(r_eidx) == last_idx);
                    n_eidx  = r_eidx + AW'(1);
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_pos   <= '0;
            r_iss   <= '0;
            r_dvld  <= 1'b0;
            r_eidx  <= '0;
            r_pend  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_pos   <= n_pos;
            r_iss   <= n_iss;
            r_dvld  <= n_dvld;
            r_eidx  <= n_eidx;
            r_pend  <= n_pend;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx   <= n_didx;
        r_plast  <= n_plast;
        r_best   <= n_best;
        r_bidx   <= n_bidx;
        r_posval <= n_posval;
        r_odata  <= n_odata;
        r_olast  <= n_olast;
        r_ouser  <= n_ouser;
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ouser;

endmodule

// File: rtl/ssort_checker.sv
module ssort_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // intake is shut once the closing word has been taken
    a_close_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("intake open right after set closed");

    // intake stays shut while a set is mid-emission
    a_emit_shut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("intake open during emission");

endmodule

bind selection_sorter_core ssort_checker u_ssort_checker (.*);

// File: verif/selection_sorter_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the sorter. It keeps its own copy of the element
// store and, when a set closes, works out the sorted words that must come out.
module selection_sorter_checker
    import ssort_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_word       i_in_data,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_word       i_out_data,
    input  logic        i_out_last,
    input  logic        i_out_dropped,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);

    typedef struct {
        t_word value;
        logic  run_end;
        logic  dropped;
    } t_sorted_word;

    t_sorted_word sorted_q[$];
    t_word        held[DEPTH];
    int unsigned  held_count;
    logic         overflow_seen;
    int unsigned  mismatch_count;

    always @(posedge i_clk) begin : watch
        t_word        ordered[DEPTH];
        t_word        swap_tmp;
        int unsigned  best;
        t_sorted_word got_exp;

        if (!i_rst_n) begin
            sorted_q.delete();
            held_count     = 0;
            overflow_seen  = 1'b0;
            mismatch_count = 0;
        end else begin
            // output side first: a word leaving now belongs to an older set
            if (i_out_valid && i_out_ready) begin
                if (sorted_q.size() == 0) begin
                    $display("%0t: unexpected word: actual %0d last %b dropped %b",
                             $time, i_out_data, i_out_last, i_out_dropped);
                    mismatch_count++;
                end else begin
                    got_exp = sorted_q.pop_front();
                    if (got_exp.value !== i_out_data || got_exp.run_end !== i_out_last
                            || got_exp.dropped !== i_out_dropped) begin
                        $display("%0t: mismatch: expected %0d last %b dropped %b, actual %0d last %b dropped %b",
                                 $time, got_exp.value, got_exp.run_end, got_exp.dropped,
                                 i_out_data, i_out_last, i_out_dropped);
                        mismatch_count++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (held_count < DEPTH) begin
                    held[held_count] = i_in_data;
                    held_count++;
                end else begin
                    overflow_seen = 1'b1;
                end
                if (i_in_last) begin
                    for (int k = 0; k < DEPTH; k++) ordered[k] = held[k];
                    // selection sort, strict less keeps the earliest of equals
                    for (int unsigned pos = 0; pos + 1 < held_count; pos++) begin
                        best = pos;
                        for (int unsigned k = pos + 1; k < held_count; k++)
                            if (ordered[k] < ordered[best]) best = k;
                        swap_tmp       = ordered[pos];
                        ordered[pos]   = ordered[best];
                        ordered[best]  = swap_tmp;
                    end
                    for (int unsigned k = 0; k < held_count; k++) begin
                        got_exp.value   = ordered[k];
                        got_exp.run_end = (k + 1 == held_count);
                        got_exp.dropped = overflow_seen;
                        sorted_q.push_back(got_exp);
                    end
                    held_count    = 0;
                    overflow_seen = 1'b0;
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= sorted_q.size();
    end

endmodule

// File: verif/selection_sorter_core_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the selection sorter. Sets of signed words go in
// on the slave side; the checker beside the block predicts the sorted output.
module selection_sorter_core_test;
    import ssort_pkg::*;

    localparam int DEPTH = 64;
    // Worst full set: a sort of 64 words plus a stalled drain of 64 words.
    // The whole run stays far below this; it only catches a hang.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    t_word       s_tdata = '0;
    logic        s_tlast = 1'b0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // idling odds in percent, set per phase
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;

    int unsigned fail_count;
    int unsigned pending_words;
    int unsigned cycle_count = 0;

    selection_sorter_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),   // [31:0] sample_value
        .s_axis_tlast  (s_tlast),   // is_last
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),   // [31:0] sorted_value
        .m_axis_tlast  (m_tlast),   // run_end
        .m_axis_tuser  (m_tuser)    // [0] dropped_flag
    );

    selection_sorter_checker #(
        .DEPTH(DEPTH)
    ) sort_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_tvalid),
        .i_in_ready    (s_tready),
        .i_in_data     (s_tdata),
        .i_in_last     (s_tlast),
        .i_out_valid   (m_tvalid),
        .i_out_ready   (m_tready),
        .i_out_data    (m_tdata),
        .i_out_last    (m_tlast),
        .i_out_dropped (m_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending_words)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // sink side: stall at random, odds per phase
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Mostly full-range random words; some extremes and some from a narrow
    // band so that sets hold equal values.
    function automatic t_word pick_sample();
        case ($urandom_range(7, 0))
            0: begin
                case ($urandom_range(3, 0))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
            1:       return t_word'(int'($urandom_range(6, 0)) - 3);
            default: return t_word'($urandom);
        endcase
    endfunction

    // Sends one set, tlast on the final word. Each word may be preceded by
    // random idle cycles. A word counts as taken at the first edge that sees
    // tready high while it is offered.
    task automatic send_set(input t_word vals[$]);
        for (int k = 0; k < vals.size(); k++) begin
            while ($urandom_range(99, 0) < idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= vals[k];
            s_tlast  <= (k == vals.size() - 1);
            do @(posedge i_clk); while (!s_tready);
        end
    endtask

    // Source goes quiet until the checker holds no expected word.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    initial begin : stimulus
        t_word       vals[$];
        int unsigned phase_items;
        int unsigned small_goal;
        int unsigned big_len;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single-word sets at both ends of the range
        vals = '{32'sh7FFF_FFFF};
        send_set(vals);
        vals = '{32'sh8000_0000};
        send_set(vals);
        // extremes with duplicates
        vals = '{32'sh7FFF_FFFF, -32'sd1, 32'sh8000_0000, 32'sd0, 32'sd1,
                 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 32'sd0};
        send_set(vals);
        // already descending, already ascending
        vals = '{32'sd4, 32'sd3, 32'sd2, 32'sd1, 32'sd0};
        send_set(vals);
        vals = '{-32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2};
        send_set(vals);

        // Random phases. Each starts from a drained block. Phase 0: no idling,
        // only short sets. Phase 1: source idles 72%, only short sets.
        // Phase 2: sink stalls 72%, closes with a set three over the store so
        // the tlast word itself is among the dropped. Phase 3: both idle 17%,
        // closes with a set filling the store exactly.
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  big_len = 0;         end
                1: begin idle_pct = 72; stall_pct = 0;  big_len = 0;         end
                2: begin idle_pct = 0;  stall_pct = 72; big_len = DEPTH + 3; end
                default: begin
                    idle_pct = 17; stall_pct = 17; big_len = DEPTH;
                end
            endcase
            small_goal  = (big_len == 0) ? 20 : 10;
            phase_items = 0;
            while (phase_items < small_goal) begin
                vals.delete();
                repeat ($urandom_range(10, 1)) vals.push_back(pick_sample());
                phase_items += vals.size();
                send_set(vals);
            end
            if (big_len != 0) begin
                vals.delete();
                repeat (big_len) vals.push_back(pick_sample());
                send_set(vals);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
